/* rtl/associative_key_value_table_unit_assert.svh */
// Assertion macros for the key/value table RTL.
`ifndef ASSOCIATIVE_KEY_VALUE_TABLE_UNIT_ASSERT_SVH
`define ASSOCIATIVE_KEY_VALUE_TABLE_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define AKV_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("akv assertion failed");
`define AKV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("akv assertion failed");
`else
`define AKV_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define AKV_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/akv_pkg.sv */
// Package with item types and codes for the key/value table.
`timescale 1ns / 1ps
package akv_pkg;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] key;
        logic [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic        found;
        logic [31:0] value_out;
        logic [1:0]  status;
        logic [4:0]  entry_count;
    } t_out_item;

    localparam logic [2:0] KIND_PUT      = 3'd0;
    localparam logic [2:0] KIND_GET      = 3'd1;
    localparam logic [2:0] KIND_DELETE   = 3'd2;
    localparam logic [2:0] KIND_CONTAINS = 3'd3;
    localparam logic [2:0] KIND_CLEAR    = 3'd4;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

endpackage

/* rtl/akv_store.sv */
// Key and value memories with one write port and one registered read port.
`timescale 1ns / 1ps
module akv_store #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32,
    parameter int IW         = 4
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [IW-1:0]         i_wr_addr,
    input  logic [KEY_BITS-1:0]   i_wr_key,
    input  logic [VALUE_BITS-1:0] i_wr_val,
    input  logic [IW-1:0]         i_rd_addr,
    output logic [KEY_BITS-1:0]   o_rd_key,
    output logic [VALUE_BITS-1:0] o_rd_val
);
    import akv_pkg::*;

    logic [KEY_BITS-1:0]   r_key_mem [ENTRIES];
    logic [VALUE_BITS-1:0] r_val_mem [ENTRIES];
    logic [KEY_BITS-1:0]   r_rd_key;
    logic [VALUE_BITS-1:0] r_rd_val;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_key_mem[i_wr_addr] <= i_wr_key;
            r_val_mem[i_wr_addr] <= i_wr_val;
        end
        r_rd_key <= r_key_mem[i_rd_addr];
        r_rd_val <= r_val_mem[i_rd_addr];
    end

    assign o_rd_key = r_rd_key;
    assign o_rd_val = r_rd_val;

endmodule

/* rtl/akv_ctrl.sv */
// Sequencer that scans the table through one shared key comparator.
`timescale 1ns / 1ps
module akv_ctrl #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32,
    parameter int IW         = 4,
    parameter int CW         = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  akv_pkg::t_in_item     i_in_item,
    output logic                  o_in_ready,
    input  logic                  i_out_free,
    output logic                  o_res_fire,
    output akv_pkg::t_out_item    o_res,
    output logic                  o_we,
    output logic [IW-1:0]         o_wr_addr,
    output logic [KEY_BITS-1:0]   o_wr_key,
    output logic [VALUE_BITS-1:0] o_wr_val,
    output logic [IW-1:0]         o_rd_addr,
    input  logic [KEY_BITS-1:0]   i_rd_key,
    input  logic [VALUE_BITS-1:0] i_rd_val
);
    import akv_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    logic [1:0]            r_state,     n_state;
    logic [2:0]            r_kind,      n_kind;
    logic [KEY_BITS-1:0]   r_key,       n_key;
    logic [VALUE_BITS-1:0] r_val,       n_val;
    logic [IW-1:0]         r_issue_idx, n_issue_idx;
    logic                  r_issue_on,  n_issue_on;
    logic [IW-1:0]         r_chk_idx,   n_chk_idx;
    logic                  r_chk_on,    n_chk_on;
    logic                  r_hit,       n_hit;
    logic [IW-1:0]         r_hit_idx,   n_hit_idx;
    logic [VALUE_BITS-1:0] r_hit_val,   n_hit_val;
    logic                  r_free_ok,   n_free_ok;
    logic [IW-1:0]         r_free_idx,  n_free_idx;
    logic [ENTRIES-1:0]    r_valid,     n_valid;
    logic [CW-1:0]         r_count,     n_count;

    logic chk_hit;
    logic chk_free;
    logic needs_scan;

    // The comparator sees the entry whose read was issued in the cycle before.
    assign chk_hit  = r_chk_on && r_valid[r_chk_idx] && (i_rd_key == r_key);
    assign chk_free = r_chk_on && !r_valid[r_chk_idx];

    always_comb begin
        needs_scan = 1'b0;
        case (i_in_item.kind) inside
            KIND_PUT, KIND_CONTAINS: needs_scan = 1'b1;
            KIND_GET, KIND_DELETE:   needs_scan = (r_count != '0);
            default:                 needs_scan = 1'b0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_key       = r_key;
        n_val       = r_val;
        n_issue_idx = r_issue_idx;
        n_issue_on  = r_issue_on;
        n_chk_idx   = r_chk_idx;
        n_chk_on    = 1'b0;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_hit_val   = r_hit_val;
        n_free_ok   = r_free_ok;
        n_free_idx  = r_free_idx;
        n_valid     = r_valid;
        n_count     = r_count;
        o_res_fire  = 1'b0;
        o_res       = '0;
        o_we        = 1'b0;
        o_wr_addr   = r_hit_idx;
        o_wr_key    = r_key;
        o_wr_val    = r_val;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_kind      = i_in_item.kind;
                    n_key       = KEY_BITS'(i_in_item.key);
                    n_val       = VALUE_BITS'(i_in_item.value);
                    n_hit       = 1'b0;
                    n_free_ok   = 1'b0;
                    n_issue_idx = '0;
                    n_issue_on  = needs_scan;
                    n_state     = needs_scan ? ST_SCAN : ST_COMMIT;
                end
            end
            ST_SCAN: begin
                if (r_issue_on) begin
                    n_chk_on  = 1'b1;
                    n_chk_idx = r_issue_idx;
                    if (r_issue_idx == LAST_IDX) begin
                        n_issue_on = 1'b0;
                    end else begin
                        n_issue_idx = r_issue_idx + IW'(1);
                    end
                end
                if (chk_hit && !r_hit) begin
                    n_hit     = 1'b1;
                    n_hit_idx = r_chk_idx;
                    n_hit_val = i_rd_val;
                end
                if (chk_free && !r_free_ok) begin
                    n_free_ok  = 1'b1;
                    n_free_idx = r_chk_idx;
                end
                if (r_chk_on && r_chk_idx == LAST_IDX) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (i_out_free) begin
                    o_res_fire = 1'b1;
                    n_state    = ST_IDLE;
                    case (r_kind) inside
                        KIND_PUT: begin
                            if (r_hit) begin
                                o_res.found     = 1'b1;
                                o_res.value_out = 32'(r_hit_val);
                                o_we            = 1'b1;
                            end else if (r_free_ok) begin
                                o_we                = 1'b1;
                                o_wr_addr           = r_free_idx;
                                n_valid[r_free_idx] = 1'b1;
                                n_count             = r_count + CW'(1);
                            end else begin
                                o_res.status = STATUS_FULL;
                            end
                        end
                        KIND_GET, KIND_DELETE: begin
                            if (r_count == '0) begin
                                o_res.status = STATUS_EMPTY;
                            end else if (r_hit) begin
                                o_res.found     = 1'b1;
                                o_res.value_out = 32'(r_hit_val);
                                if (r_kind == KIND_DELETE) begin
                                    n_valid[r_hit_idx] = 1'b0;
                                    n_count            = r_count - CW'(1);
                                end
                            end
                        end
                        KIND_CONTAINS: begin
                            o_res.found = r_hit;
                        end
                        KIND_CLEAR: begin
                            n_valid = '0;
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        o_res.entry_count = 5'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_issue_on <= 1'b0;
            r_chk_on   <= 1'b0;
            r_valid    <= '0;
            r_count    <= '0;
        end else begin
            r_state    <= n_state;
            r_issue_on <= n_issue_on;
            r_chk_on   <= n_chk_on;
            r_valid    <= n_valid;
            r_count    <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_key       <= n_key;
        r_val       <= n_val;
        r_issue_idx <= n_issue_idx;
        r_chk_idx   <= n_chk_idx;
        r_hit       <= n_hit;
        r_hit_idx   <= n_hit_idx;
        r_hit_val   <= n_hit_val;
        r_free_ok   <= n_free_ok;
        r_free_idx  <= n_free_idx;
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign o_rd_addr  = r_issue_idx;

endmodule

/* rtl/associative_key_value_table_unit.sv */
// Top level of the linearly searched key/value table with its output register.
//
// Usage: a request item (kind, key, value) enters on the input channel when
// i_in_valid and o_in_ready are both high; one result item (found, value_out,
// status, entry_count) leaves on the output channel when o_out_valid and
// i_out_ready are both high. Every request gives exactly one result.
// Put, get, delete and contains sweep all ENTRIES slots through one key
// comparator, one slot per cycle, behind the registered memory read. Such an
// item then waits in the commit step until the output register is free, and
// the next item is taken only once the sequencer is back in idle.
// Clear, unknown kinds and get or delete on an empty table skip the sweep
// and go straight to the commit step.
// The result sits in an output register, so the sweep runs while an earlier
// result waits; if the receiver still stalls when the next result is ready,
// the sequencer holds it and o_in_ready stays low until the register frees.
// Reset (synchronous, active low) clears the valid marks, the entry count
// and the output valid bit; the key/value memories and result are not cleared.
`timescale 1ns / 1ps
`include "associative_key_value_table_unit_assert.svh"
module associative_key_value_table_unit #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  akv_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output akv_pkg::t_out_item o_out_item
);
    import akv_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    logic                  res_fire;
    t_out_item             res;
    logic                  out_free;
    logic                  in_ready;
    logic                  we;
    logic [IW-1:0]         wr_addr;
    logic [KEY_BITS-1:0]   wr_key;
    logic [VALUE_BITS-1:0] wr_val;
    logic [IW-1:0]         rd_addr;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_val;

    logic      r_out_valid;
    t_out_item r_out_item;

    assign out_free = !r_out_valid || i_out_ready;

    akv_ctrl #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS),
        .IW         (IW),
        .CW         (CW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_ready (in_ready),
        .i_out_free (out_free),
        .o_res_fire (res_fire),
        .o_res      (res),
        .o_we       (we),
        .o_wr_addr  (wr_addr),
        .o_wr_key   (wr_key),
        .o_wr_val   (wr_val),
        .o_rd_addr  (rd_addr),
        .i_rd_key   (rd_key),
        .i_rd_val   (rd_val)
    );

    akv_store #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS),
        .IW         (IW)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_wr_addr (wr_addr),
        .i_wr_key  (wr_key),
        .i_wr_val  (wr_val),
        .i_rd_addr (rd_addr),
        .o_rd_key  (rd_key),
        .o_rd_val  (rd_val)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_fire) begin
            r_out_item <= res;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // An accepted item leaves the sequencer busy in the cycle after acceptance.
    `AKV_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    // A new result never overwrites one the receiver has not taken.
    `AKV_ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, res_fire, !r_out_valid || i_out_ready)
    // A found key never comes with an error status.
    `AKV_ASSERT_IMPL(a_found_ok, i_clk, i_rst_n, res_fire && res.found, res.status == STATUS_OK)
    // The count reported never exceeds the capacity.
    `AKV_ASSERT_IMPL(a_count_cap, i_clk, i_rst_n, o_out_valid && (ENTRIES < 32), o_out_item.entry_count <= 5'(ENTRIES))

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the associative key/value table unit.
`timescale 1ns / 1ps
module tb_top;
    import akv_pkg::*;

    localparam int ENTRIES       = 16;
    localparam int POOL_SIZE     = 24;
    localparam int RANDOM_ITEMS  = 1350;
    localparam int HOLD_AT       = 300;
    localparam int PAUSE_AT      = 700;
    localparam int HOLD_CYCLES   = 400;
    localparam int END_SETTLE    = 40;
    localparam int STALL_LIMIT   = 4000;
    localparam int REPORT_LIMIT  = 10;
    localparam logic [2:0] KIND_LAST = 3'd7;

    typedef enum int {MODE_FILL, MODE_MIX, MODE_DRAIN, MODE_QUERY} t_burst_mode;

    typedef struct {
        t_in_item  req;
        bit        typed;
        t_out_item result;
    } t_directed_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    t_in_item  i_in_item = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_item;

    // Shadow copy of the table contents.
    logic [31:0] table_key [ENTRIES];
    logic [31:0] table_value [ENTRIES];
    bit          table_live [ENTRIES];
    int          live_count;

    t_out_item     pending_results [$];
    t_directed_row directed_rows [$];
    logic [31:0]   key_pool [POOL_SIZE];

    int  mismatch_count;
    int  result_count;
    int  kind_count [8];
    int  full_count;
    int  empty_count;
    int  hit_count;
    int  peak_count;
    bit  hold_request;
    bit  hold_done;

    associative_key_value_table_unit #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (32),
        .VALUE_BITS (32)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Applies one request to the shadow table and returns the result it must give.
    function automatic t_out_item predict_table_result(input t_in_item req);
        t_out_item res;
        int        hit;
        int        free_slot;
        res = '0;
        hit = -1;
        free_slot = -1;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (table_live[i] && table_key[i] == req.key) hit = i;
            if (!table_live[i]) free_slot = i;
        end
        kind_count[req.kind]++;
        case (req.kind)
            KIND_PUT: begin
                if (hit >= 0) begin
                    res.found = 1'b1;
                    res.value_out = table_value[hit];
                    table_value[hit] = req.value;
                end else if (free_slot >= 0) begin
                    table_key[free_slot] = req.key;
                    table_value[free_slot] = req.value;
                    table_live[free_slot] = 1'b1;
                    live_count++;
                end else begin
                    res.status = STATUS_FULL;
                    full_count++;
                end
            end
            KIND_GET, KIND_DELETE: begin
                if (live_count == 0) begin
                    res.status = STATUS_EMPTY;
                    empty_count++;
                end else if (hit >= 0) begin
                    res.found = 1'b1;
                    res.value_out = table_value[hit];
                    if (req.kind == KIND_DELETE) begin
                        table_live[hit] = 1'b0;
                        live_count--;
                    end
                end
            end
            KIND_CONTAINS: res.found = (hit >= 0);
            KIND_CLEAR: begin
                foreach (table_live[i]) table_live[i] = 1'b0;
                live_count = 0;
            end
            default: ;
        endcase
        if (res.found) hit_count++;
        if (live_count > peak_count) peak_count = live_count;
        res.entry_count = 5'(live_count);
        return res;
    endfunction

    function automatic void add_row(input logic [2:0] kind, input logic [31:0] key,
                                    input logic [31:0] value, input bit typed,
                                    input logic found, input logic [31:0] value_out,
                                    input logic [1:0] status, input logic [4:0] entry_count);
        t_directed_row row;
        row.req = '{kind: kind, key: key, value: value};
        row.typed = typed;
        row.result = '{found: found, value_out: value_out, status: status,
                       entry_count: entry_count};
        directed_rows.push_back(row);
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic t_in_item make_request(input t_burst_mode mode);
        t_in_item req;
        int       roll;
        int       vroll;
        roll = $urandom_range(0, 99);
        vroll = $urandom_range(0, 19);
        req.key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                               : $urandom;
        req.value = (vroll == 0) ? 32'h0 : (vroll == 1) ? 32'hFFFF_FFFF : $urandom;
        case (mode)
            MODE_FILL:
                req.kind = (roll < 70) ? KIND_PUT : (roll < 80) ? KIND_GET :
                           (roll < 90) ? KIND_CONTAINS : KIND_DELETE;
            MODE_MIX:
                req.kind = (roll < 25) ? KIND_PUT : (roll < 50) ? KIND_GET :
                           (roll < 75) ? KIND_DELETE : KIND_CONTAINS;
            MODE_DRAIN:
                req.kind = (roll < 60) ? KIND_DELETE : (roll < 80) ? KIND_GET : KIND_CONTAINS;
            default:
                req.kind = (roll < 15) ? KIND_PUT : (roll < 55) ? KIND_GET :
                           (roll < 60) ? KIND_DELETE : KIND_CONTAINS;
        endcase
        return req;
    endfunction

    // Offers one item, holding it until accepted, then records what it must produce.
    task automatic send_request(input t_in_item req, input bit typed,
                                input t_out_item typed_result, input int gap);
        t_out_item predicted;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = predict_table_result(req);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(posedge i_clk);
    endtask

    function automatic void report_mismatch(input string what, input t_out_item want);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("[%0t] result %0d %s: expected found=%0b value=%h status=%0d count=%0d, got found=%0b value=%h status=%0d count=%0d",
                     $realtime, result_count, what, want.found, want.value_out, want.status,
                     want.entry_count, o_out_item.found, o_out_item.value_out,
                     o_out_item.status, o_out_item.entry_count);
    endfunction

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            result_count++;
            if (pending_results.size() == 0) begin
                report_mismatch("arrived with nothing pending", '0);
            end else begin
                want = pending_results.pop_front();
                if (o_out_item.found !== want.found)
                    report_mismatch("found differs", want);
                if (o_out_item.value_out !== want.value_out)
                    report_mismatch("value_out differs", want);
                if (o_out_item.status !== want.status)
                    report_mismatch("status differs", want);
                if (o_out_item.entry_count !== want.entry_count)
                    report_mismatch("entry_count differs", want);
            end
        end
    end

    initial begin : receiver
        int roll;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            roll = $urandom_range(0, 99);
            if (hold_request && !hold_done) begin
                // Long back-pressure so that the table backs up into its input.
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (roll < 30) begin
                i_out_ready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ((roll < 35) ? $urandom_range(30, 80) : $urandom_range(1, 8))
                    @(posedge i_clk);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet = 0;
            else quiet++;
        end
        $display("watchdog: no item accepted for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        t_burst_mode mode;
        t_in_item    req;
        int          random_sent;
        int          noise_sent;
        int          burst_len;
        int          roll;
        bit          quiet_burst;

        foreach (table_live[i]) table_live[i] = 1'b0;
        live_count = 0;
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;

        add_row(KIND_GET, 32'h0, 32'h0, 1, 1'b0, 32'h0, STATUS_EMPTY, 5'd0);
        add_row(KIND_DELETE, 32'hFFFF_FFFF, 32'h0, 1, 1'b0, 32'h0, STATUS_EMPTY, 5'd0);
        add_row(KIND_CONTAINS, 32'h0, 32'h0, 1, 1'b0, 32'h0, STATUS_OK, 5'd0);
        add_row(KIND_PUT, 32'h0, 32'hFFFF_FFFF, 1, 1'b0, 32'h0, STATUS_OK, 5'd1);
        add_row(KIND_PUT, 32'hFFFF_FFFF, 32'h0, 1, 1'b0, 32'h0, STATUS_OK, 5'd2);
        add_row(KIND_PUT, 32'h0, 32'hA5A5_A5A5, 1, 1'b1, 32'hFFFF_FFFF, STATUS_OK, 5'd2);
        add_row(KIND_GET, 32'h0, 32'h0, 1, 1'b1, 32'hA5A5_A5A5, STATUS_OK, 5'd2);
        add_row(KIND_CONTAINS, 32'hFFFF_FFFF, 32'h0, 1, 1'b1, 32'h0, STATUS_OK, 5'd2);
        add_row(KIND_GET, 32'h5A5A_5A5A, 32'h0, 1, 1'b0, 32'h0, STATUS_OK, 5'd2);
        add_row(KIND_DELETE, 32'h0, 32'hFFFF_FFFF, 1, 1'b1, 32'hA5A5_A5A5, STATUS_OK, 5'd1);
        add_row(KIND_DELETE, 32'h0, 32'h0, 1, 1'b0, 32'h0, STATUS_OK, 5'd1);
        add_row(KIND_LAST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b0, 32'h0, STATUS_OK, 5'd1);
        // Fill the remaining slots; the reused slot of the deleted key comes first.
        for (int i = 1; i < ENTRIES; i++)
            add_row(KIND_PUT, 32'h3C00_0000 | i, $urandom, 0, 1'b0, 32'h0, STATUS_OK, 5'd0);
        add_row(KIND_PUT, 32'h0, 32'h1, 1, 1'b0, 32'h0, STATUS_FULL, 5'd16);
        add_row(KIND_PUT, 32'hFFFF_FFFF, 32'h1234_5678, 1, 1'b1, 32'h0, STATUS_OK, 5'd16);
        add_row(KIND_CLEAR, 32'h0, 32'h0, 1, 1'b0, 32'h0, STATUS_OK, 5'd0);
        add_row(KIND_GET, 32'hFFFF_FFFF, 32'h0, 1, 1'b0, 32'h0, STATUS_EMPTY, 5'd0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r])
            send_request(directed_rows[r].req, directed_rows[r].typed,
                         directed_rows[r].result, pick_gap());
        wait_for_drain();

        random_sent = 0;
        noise_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            mode = t_burst_mode'($urandom_range(0, 3));
            burst_len = $urandom_range(10, 60);
            quiet_burst = ($urandom_range(0, 3) == 0);
            for (int b = 0; b < burst_len && random_sent < RANDOM_ITEMS; b++) begin
                if (random_sent == HOLD_AT) hold_request = 1'b1;
                if (random_sent == PAUSE_AT && noise_sent >= 0) begin
                    wait_for_drain();
                    noise_sent = -noise_sent - 1;
                end
                roll = $urandom_range(0, 199);
                if (roll < 3) begin
                    req = '{kind: KIND_CLEAR, key: $urandom, value: $urandom};
                end else if (roll < 9) begin
                    req = '{kind: 3'($urandom_range(int'(KIND_CLEAR) + 1, int'(KIND_LAST))),
                            key: $urandom, value: $urandom};
                end else begin
                    req = make_request(mode);
                end
                send_request(req, 1'b0, '0, quiet_burst ? 0 : pick_gap());
                if (req.kind > KIND_CLEAR) noise_sent += (noise_sent < 0) ? -1 : 1;
                else random_sent++;
            end
        end

        wait_for_drain();
        repeat (END_SETTLE) @(posedge i_clk);

        $display("covered %0d results: put %0d, get %0d, delete %0d, contains %0d, clear %0d, unused kinds %0d",
                 result_count, kind_count[KIND_PUT], kind_count[KIND_GET],
                 kind_count[KIND_DELETE], kind_count[KIND_CONTAINS], kind_count[KIND_CLEAR],
                 kind_count[5] + kind_count[6] + kind_count[7]);
        $display("key hits %0d, inserts refused on a full table %0d, lookups on an empty table %0d, peak occupancy %0d, mismatches %0d",
                 hit_count, full_count, empty_count, peak_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* associative_key_value_table_unit.f */
+incdir+rtl
rtl/akv_pkg.sv
rtl/akv_store.sv
rtl/akv_ctrl.sv
rtl/associative_key_value_table_unit.sv
verif/tb_top.sv
